// ===== rtl/bbc_pkg.sv =====
// shared types and constants for the bracket balance checker
package bbc_pkg;

   // bracket kind as held on the stack
   typedef logic [1:0] kind_type;

   localparam kind_type KIND_PAREN  = 2'd0;
   localparam kind_type KIND_BRACE  = 2'd1;
   localparam kind_type KIND_SQUARE = 2'd2;
   localparam kind_type KIND_NONE   = 2'd3;

   // result status codes
   typedef logic [2:0] status_type;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_MISMATCH  = 3'd1;
   localparam status_type ST_UNDERFLOW = 3'd2;
   localparam status_type ST_UNCLOSED  = 3'd3;
   localparam status_type ST_OVERFLOW  = 3'd4;

   // character codes
   localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
   localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;
   localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
   localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
   localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

   // configuration
   localparam int          LIMIT_W     = 7;
   localparam logic [6:0]  LIMIT_RESET = 7'd40;

   // kind of an opening bracket, KIND_NONE otherwise
   function automatic kind_type open_kind(input logic [7:0] c);
      unique case (c)
         CH_OPEN_PAREN:  open_kind = KIND_PAREN;
         CH_OPEN_BRACE:  open_kind = KIND_BRACE;
         CH_OPEN_SQUARE: open_kind = KIND_SQUARE;
         default:        open_kind = KIND_NONE;
      endcase
   endfunction

   // kind of a closing bracket, KIND_NONE otherwise
   function automatic kind_type close_kind(input logic [7:0] c);
      unique case (c)
         CH_CLOSE_PAREN:  close_kind = KIND_PAREN;
         CH_CLOSE_BRACE:  close_kind = KIND_BRACE;
         CH_CLOSE_SQUARE: close_kind = KIND_SQUARE;
         default:         close_kind = KIND_NONE;
      endcase
   endfunction

endpackage

// ===== rtl/bbc_ram.sv =====
// generic single-write, single-read ram with registered read data
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// bracket balance checker top level: stack control, ram and result register
// result: the result of a final character is registered and valid in the cycle after its transaction
// throughput: one character per cycle while req_ready is high; the top of stack sits in a
//   register and the ram read for the entry below it is issued ahead, so pushes and pops run back to back
// reset: stack count, sticky error and output valid clear; depth limit returns to 40;
//   stack ram contents are not cleared
module bracket_balance_checker #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_code,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_balanced,
   output bbc_pkg::status_type       rsp_status,
   input  logic                      csr_wr_en,
   input  logic [bbc_pkg::LIMIT_W-1:0] csr_wr_data
);

   import bbc_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   // configuration
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // stack state
   logic [CW-1:0] count_ff, count_mid, count_in;
   status_type    err_ff, err_mid, err_in;
   kind_type      tos_ff, tos_in;
   logic          fwd_ff;
   kind_type      fwd_data_ff;
   kind_type      ram_rd_data, below;

   // output register
   logic          rsp_valid_ff;
   logic          balanced_ff;
   status_type    status_ff;

   logic          accept;
   kind_type      okind, ckind;
   logic [LW-1:0] lim_ext, dl_ext, depth_ext, count_ext;
   logic          overflow;
   logic          push, pop;
   logic          mem_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CW-1:0] rd_ptr;
   status_type    final_status;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // decode and effective depth limit
   always_comb begin
      okind     = open_kind(req_char_code);
      ckind     = close_kind(req_char_code);
      dl_ext    = LW'(limit_ff);
      depth_ext = LW'(STACK_DEPTH);
      lim_ext   = (dl_ext > depth_ext) ? depth_ext : dl_ext;
      count_ext = LW'(count_ff);
      overflow  = count_ext >= lim_ext;
   end

   // entry under the top: forwarded when it was written in the last cycle
   assign below = fwd_ff ? fwd_data_ff : ram_rd_data;

   // stack update for one transaction
   always_comb begin
      push      = 1'b0;
      pop       = 1'b0;
      count_mid = count_ff;
      err_mid   = err_ff;
      if (accept && (err_ff == ST_OK)) begin
         if (okind != KIND_NONE) begin
            if (overflow) begin
               err_mid = ST_OVERFLOW;
            end else begin
               push      = 1'b1;
               count_mid = count_ff + CW'(1);
            end
         end else if (ckind != KIND_NONE) begin
            if (count_ff == '0) begin
               err_mid = ST_UNDERFLOW;
            end else begin
               pop       = 1'b1;
               count_mid = count_ff - CW'(1);
               if (tos_ff != ckind) begin
                  err_mid = ST_MISMATCH;
               end
            end
         end
      end

      priority if (err_mid != ST_OK) begin
         final_status = err_mid;
      end else if (count_mid != '0) begin
         final_status = ST_UNCLOSED;
      end else begin
         final_status = ST_OK;
      end

      if (accept && req_last) begin
         count_in = '0;
         err_in   = ST_OK;
      end else begin
         count_in = count_mid;
         err_in   = err_mid;
      end

      priority if (push) begin
         tos_in = okind;
      end else if (pop) begin
         tos_in = below;
      end else begin
         tos_in = tos_ff;
      end
   end

   // old top spills to ram on a push over a nonempty stack
   assign mem_we  = push && (count_ff != '0);
   assign wr_addr = AW'(count_ff - CW'(1));
   // prefetch the entry under the next top
   assign rd_ptr  = count_in - CW'(2);
   assign rd_addr = rd_ptr[AW-1:0];

   bbc_ram #(
      .WIDTH($bits(kind_type)),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (tos_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= ST_OK;
         fwd_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
         fwd_ff   <= mem_we;
      end
   end

   // top of stack and forwarded entry
   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      fwd_data_ff <= tos_ff;
   end

   // result transaction register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         balanced_ff <= (final_status == ST_OK);
         status_ff   <= final_status;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_balanced = balanced_ff;
   assign rsp_status   = status_ff;

endmodule
